### rtl/core/esd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the escaped string decoder.
// No dependencies; every file of the block but the two interfaces uses this package.
package esd_pkg;

   localparam int LENGTH_BITS_DEF = 16;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;

   // register indexes (byte address / 4)
   localparam logic [0:0] REG_QUOTE_CHAR = 1'b0;
   localparam logic [7:0] QUOTE_RESET    = 8'h22;

   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_X      = 8'h78;
   localparam logic [7:0] CHAR_U      = 8'h75;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_0      = 8'h30;
   localparam logic [7:0] CHAR_9      = 8'h39;
   localparam logic [7:0] CHAR_LA     = 8'h61;
   localparam logic [7:0] CHAR_LF     = 8'h66;
   localparam logic [7:0] CHAR_UA     = 8'h41;
   localparam logic [7:0] CHAR_UF     = 8'h46;
   localparam logic [7:0] CTRL_TAB    = 8'h09;
   localparam logic [7:0] CTRL_CR     = 8'h0D;
   localparam logic [7:0] CTRL_LF     = 8'h0A;

   localparam logic [15:0] UTF8_MAX1  = 16'h007F;
   localparam logic [15:0] UTF8_MAX2  = 16'h07FF;
   localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0]  UTF8_CONT  = 8'h80;

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'd0,
      MODE_PLAIN = 3'd1,
      MODE_ESC   = 3'd2,
      MODE_HEX   = 3'd3,
      MODE_UNI   = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_END  = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      kind_type    result_kind;
      logic [15:0] decoded_length;
      logic        last_of_run;
   } result_type;

   // up to three results caused by one request, slot 0 first
   typedef struct packed {
      logic                  load;
      result_type [2:0]      res;
   } bundle_type;

   typedef struct packed {
      logic free;
   } status_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_digit(input logic [7:0] b);
      hex_type h;
      h = '0;
      if (b >= CHAR_0 && b <= CHAR_9) begin
         h.valid = 1'b1;
         h.value = 4'(b - CHAR_0);
      end else if (b >= CHAR_LA && b <= CHAR_LF) begin
         h.valid = 1'b1;
         h.value = 4'(b - CHAR_LA + 8'd10);
      end else if (b >= CHAR_UA && b <= CHAR_UF) begin
         h.valid = 1'b1;
         h.value = 4'(b - CHAR_UA + 8'd10);
      end
      return h;
   endfunction

endpackage

### rtl/core/esd_req_if.sv
`timescale 1ns / 1ps
// Request channel of the escaped string decoder: one raw byte per transfer.
// No dependencies.
interface esd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

### rtl/core/esd_rsp_if.sv
`timescale 1ns / 1ps
// Result channel of the escaped string decoder.
// No dependencies.
interface esd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic [1:0]  result_kind;
   logic [15:0] decoded_length;
   logic        last_of_run;

   modport source (output valid, output out_byte, output result_kind,
                   output decoded_length, output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input result_kind,
                   input decoded_length, input last_of_run, output ready);
endinterface

### rtl/core/escaped_string_decoder.sv
`timescale 1ns / 1ps
// Escaped string decoder: takes one raw byte of a quoted literal per request
// and returns decoded bytes, an end-of-string result with the saturating length,
// or an error on a bad hex digit. Each request is held in a request register,
// decoded in one pass and its results (up to three, for a \u escape encoded as
// UTF-8) placed in a result register. A new request is taken every cycle while
// the result side is ready and each request gives at most one result; a request
// giving several results holds the result port until the last is taken, so the
// single result port sets the rate. quote_char sits at byte address 0.
// Depends on esd_pkg, esd_req_if, esd_rsp_if, esd_csr, esd_decode and esd_out.
module escaped_string_decoder #(
   parameter int LENGTH_BITS = esd_pkg::LENGTH_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   esd_req_if.sink                           req_ch,
   esd_rsp_if.source                         rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [esd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [esd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [esd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   logic [7:0]           quote_char;
   esd_pkg::bundle_type  bundle;
   esd_pkg::status_type  out_status;

   esd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .quote_char  (quote_char)
   );

   esd_decode #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_decode (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .quote_char (quote_char),
      .out_status (out_status),
      .bundle     (bundle)
   );

   esd_out u_out (
      .clock      (clock),
      .reset      (reset),
      .bundle     (bundle),
      .out_status (out_status),
      .rsp_ch     (rsp_ch)
   );

   // end and error results always stand alone
   a_single_end: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.result_kind == esd_pkg::KIND_END ||
                       rsp_ch.result_kind == esd_pkg::KIND_ERR) |-> rsp_ch.last_of_run)
      else $error("end or error result not last of its run");

   // the rest of a run follows with no gap
   a_run_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ready && !rsp_ch.last_of_run |=> rsp_ch.valid)
      else $error("gap inside a run of results");

   // requests stall only behind a pending result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> rsp_ch.valid)
      else $error("request stalled with result register empty");

endmodule

### rtl/core/esd_csr.sv
`timescale 1ns / 1ps
// APB-style register file of the decoder: holds quote_char.
// Depends on esd_pkg.
module esd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [esd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [esd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [esd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output logic [7:0]                        quote_char
);

   logic [7:0] quote_ff;
   logic [7:0] quote_in;
   logic       hit;

   assign hit = (csr_paddr[2] == esd_pkg::REG_QUOTE_CHAR);

   always_comb begin
      quote_in = quote_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         quote_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quote_ff <= esd_pkg::QUOTE_RESET;
      end else begin
         quote_ff <= quote_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = hit ? {(esd_pkg::CSR_DATA_W - 8)'(0), quote_ff} : '0;
   assign quote_char = quote_ff;

endmodule

### rtl/core/esd_decode.sv
`timescale 1ns / 1ps
// Request register, decode state and the single-pass decoder that turns one
// byte into up to three results. Depends on esd_pkg and esd_req_if.
module esd_decode #(
   parameter int LENGTH_BITS = esd_pkg::LENGTH_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   esd_req_if.sink                 req_ch,
   input  logic [7:0]              quote_char,
   input  esd_pkg::status_type     out_status,
   output esd_pkg::bundle_type     bundle
);

   localparam logic [LENGTH_BITS-1:0] LenMax = '1;
   localparam int ShowW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

   function automatic logic [LENGTH_BITS-1:0] sat_inc(input logic [LENGTH_BITS-1:0] x);
      return (x == LenMax) ? x : x + 1'b1;
   endfunction

   function automatic logic [15:0] shown(input logic [LENGTH_BITS-1:0] x);
      logic [ShowW-1:0] ext;
      ext = ShowW'(x);
      return (ext > ShowW'(16'hFFFF)) ? 16'hFFFF : ext[15:0];
   endfunction

   logic                    in_valid_ff, in_valid_in;
   logic [7:0]              in_byte_ff, in_byte_in;
   esd_pkg::mode_type       mode_ff, mode_in;
   logic [1:0]              digits_ff, digits_in;
   logic [15:0]             acc_ff, acc_in;
   logic [LENGTH_BITS-1:0]  len_ff, len_in;

   logic [LENGTH_BITS-1:0]  l1, l2, l3;
   logic [LENGTH_BITS-1:0]  len_calc;
   logic [15:0]             acc_new;
   esd_pkg::hex_type        hex;
   esd_pkg::mode_type       mode_calc;
   logic [1:0]              digits_calc;
   logic [15:0]             acc_calc;
   logic [1:0]              n;
   logic [7:0]              rb [3];
   esd_pkg::kind_type       kind0;
   logic [15:0]             len0;
   logic                    advance;
   logic [7:0]              b;

   assign b       = in_byte_ff;
   assign hex     = esd_pkg::hex_digit(b);
   assign acc_new = {acc_ff[11:0], hex.value};
   assign l1      = sat_inc(len_ff);
   assign l2      = sat_inc(l1);
   assign l3      = sat_inc(l2);

   always_comb begin
      mode_calc   = mode_ff;
      digits_calc = digits_ff;
      acc_calc    = acc_ff;
      n           = 2'd0;
      rb[0]       = 8'h00;
      rb[1]       = 8'h00;
      rb[2]       = 8'h00;
      kind0       = esd_pkg::KIND_DATA;
      len0        = shown(l1);
      unique case (mode_ff)
         esd_pkg::MODE_PLAIN: begin
            if (b == quote_char) begin
               n         = 2'd1;
               kind0     = esd_pkg::KIND_END;
               len0      = shown(len_ff);
               mode_calc = esd_pkg::MODE_IDLE;
            end else if (b == esd_pkg::CHAR_BSLASH) begin
               mode_calc = esd_pkg::MODE_ESC;
            end else begin
               n     = 2'd1;
               rb[0] = b;
            end
         end
         esd_pkg::MODE_ESC: begin
            if (b == esd_pkg::CHAR_X || b == esd_pkg::CHAR_U) begin
               mode_calc   = (b == esd_pkg::CHAR_X) ? esd_pkg::MODE_HEX : esd_pkg::MODE_UNI;
               digits_calc = 2'd0;
               acc_calc    = 16'h0000;
            end else begin
               n = 2'd1;
               if (b == esd_pkg::CHAR_T) begin
                  rb[0] = esd_pkg::CTRL_TAB;
               end else if (b == esd_pkg::CHAR_R) begin
                  rb[0] = esd_pkg::CTRL_CR;
               end else if (b == esd_pkg::CHAR_N) begin
                  rb[0] = esd_pkg::CTRL_LF;
               end else begin
                  rb[0] = b;
               end
               mode_calc = esd_pkg::MODE_PLAIN;
            end
         end
         esd_pkg::MODE_HEX, esd_pkg::MODE_UNI: begin
            if (!hex.valid) begin
               n           = 2'd1;
               kind0       = esd_pkg::KIND_ERR;
               len0        = shown(len_ff);
               mode_calc   = esd_pkg::MODE_IDLE;
               digits_calc = 2'd0;
               acc_calc    = 16'h0000;
            end else begin
               acc_calc = acc_new;
               if (mode_ff == esd_pkg::MODE_HEX && digits_ff >= 2'd1) begin
                  n           = 2'd1;
                  rb[0]       = acc_new[7:0];
                  mode_calc   = esd_pkg::MODE_PLAIN;
                  digits_calc = 2'd0;
               end else if (mode_ff == esd_pkg::MODE_UNI && digits_ff == 2'd3) begin
                  // encode the code point as UTF-8
                  if (acc_new <= esd_pkg::UTF8_MAX1) begin
                     n     = 2'd1;
                     rb[0] = acc_new[7:0];
                  end else if (acc_new <= esd_pkg::UTF8_MAX2) begin
                     n     = 2'd2;
                     rb[0] = esd_pkg::UTF8_LEAD2 | acc_new[13:6];
                     rb[1] = esd_pkg::UTF8_CONT | {2'b00, acc_new[5:0]};
                  end else begin
                     n     = 2'd3;
                     rb[0] = esd_pkg::UTF8_LEAD3 | {4'h0, acc_new[15:12]};
                     rb[1] = esd_pkg::UTF8_CONT | {2'b00, acc_new[11:6]};
                     rb[2] = esd_pkg::UTF8_CONT | {2'b00, acc_new[5:0]};
                  end
                  mode_calc   = esd_pkg::MODE_PLAIN;
                  digits_calc = 2'd0;
               end else begin
                  digits_calc = digits_ff + 2'd1;
               end
            end
         end
         default: begin
            // opening byte: skip it and start a fresh string
            mode_calc   = esd_pkg::MODE_PLAIN;
            digits_calc = 2'd0;
            acc_calc    = 16'h0000;
         end
      endcase
   end

   always_comb begin
      len_calc = len_ff;
      if (mode_ff != esd_pkg::MODE_PLAIN && mode_ff != esd_pkg::MODE_ESC &&
          mode_ff != esd_pkg::MODE_HEX && mode_ff != esd_pkg::MODE_UNI) begin
         len_calc = '0;
      end else if (kind0 == esd_pkg::KIND_DATA) begin
         case (n)
            2'd1:    len_calc = l1;
            2'd2:    len_calc = l2;
            2'd3:    len_calc = l3;
            default: len_calc = len_ff;
         endcase
      end
   end

   // requests without results never wait for the result side
   assign advance      = in_valid_ff && (n == 2'd0 || out_status.free);
   assign req_ch.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_ch.valid && req_ch.ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_ch.in_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      digits_in = digits_ff;
      acc_in    = acc_ff;
      len_in    = len_ff;
      if (advance) begin
         mode_in   = mode_calc;
         digits_in = digits_calc;
         acc_in    = acc_calc;
         len_in    = len_calc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= esd_pkg::MODE_IDLE;
         digits_ff   <= 2'd0;
         acc_ff      <= 16'h0000;
         len_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         mode_ff     <= mode_in;
         digits_ff   <= digits_in;
         acc_ff      <= acc_in;
         len_ff      <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   always_comb begin
      bundle.load                      = advance && (n != 2'd0);
      bundle.res[0].out_byte           = rb[0];
      bundle.res[0].result_kind        = kind0;
      bundle.res[0].decoded_length     = len0;
      bundle.res[0].last_of_run        = (n == 2'd1);
      bundle.res[1].out_byte           = rb[1];
      bundle.res[1].result_kind        = esd_pkg::KIND_DATA;
      bundle.res[1].decoded_length     = shown(l2);
      bundle.res[1].last_of_run        = (n == 2'd2);
      bundle.res[2].out_byte           = rb[2];
      bundle.res[2].result_kind        = esd_pkg::KIND_DATA;
      bundle.res[2].decoded_length     = shown(l3);
      bundle.res[2].last_of_run        = (n == 2'd3);
   end

endmodule

### rtl/core/esd_out.sv
`timescale 1ns / 1ps
// Result register: holds the results of one request and hands them out in
// order, one per transfer. Depends on esd_pkg and esd_rsp_if.
module esd_out (
   input  logic                 clock,
   input  logic                 reset,
   input  esd_pkg::bundle_type  bundle,
   output esd_pkg::status_type  out_status,
   esd_rsp_if.source            rsp_ch
);

   esd_pkg::result_type [2:0] res_ff;
   esd_pkg::result_type [2:0] res_in;
   logic                      valid_ff, valid_in;
   logic [1:0]                idx_ff, idx_in;
   esd_pkg::result_type       cur;
   logic                      take;
   logic                      last_take;

   assign cur       = res_ff[idx_ff];
   assign take      = valid_ff && rsp_ch.ready;
   assign last_take = take && cur.last_of_run;

   assign out_status.free = !valid_ff || last_take;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      res_in   = res_ff;
      if (bundle.load) begin
         valid_in = 1'b1;
         idx_in   = 2'd0;
         res_in   = bundle.res;
      end else if (last_take) begin
         valid_in = 1'b0;
      end else if (take) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_ch.valid          = valid_ff;
   assign rsp_ch.out_byte       = cur.out_byte;
   assign rsp_ch.result_kind    = cur.result_kind;
   assign rsp_ch.decoded_length = cur.decoded_length;
   assign rsp_ch.last_of_run    = cur.last_of_run;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for escaped_string_decoder: feeds raw literal bytes, decodes
// them alongside the block and compares every result in order.
// Depends on esd_pkg, esd_req_if, esd_rsp_if and the decoder RTL.
module testbench;
   import esd_pkg::*;

   localparam int LONG_HOLD_CYCLES = 80;
   localparam int DRAIN_CYCLES     = 4;
   localparam int QUOTE_REG        = int'(REG_QUOTE_CHAR);
   localparam int UNUSED_REG       = 1;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   esd_req_if req_bus();
   esd_rsp_if rsp_bus();

   escaped_string_decoder uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // mirror of the decoder state
   mode_type                   dec_mode;
   logic [1:0]                 dec_digits;
   logic [15:0]                dec_code;
   logic [LENGTH_BITS_DEF-1:0] dec_length;
   logic [7:0]                 dec_quote;

   result_type expected_results[$];
   result_type byte_results[$];

   int error_count       = 0;
   int bytes_sent        = 0;
   bit req_offered       = 1'b0;
   bit req_idling        = 1'b0;
   bit rsp_idling        = 1'b0;
   bit long_hold_pending = 1'b0;

   always #1 clock = ~clock;

   function automatic int digit_value(input logic [7:0] b);
      if (b >= CHAR_0 && b <= CHAR_9) return int'(b - CHAR_0);
      if (b >= CHAR_LA && b <= CHAR_LF) return int'(b - CHAR_LA) + 10;
      if (b >= CHAR_UA && b <= CHAR_UF) return int'(b - CHAR_UA) + 10;
      return -1;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return 8'(CHAR_0 + v);
      return 8'(($urandom_range(0, 1) ? CHAR_LA : CHAR_UA) + (v - 4'd10));
   endfunction

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      while (b == dec_quote || b == CHAR_BSLASH) b = 8'($urandom_range(0, 255));
      return b;
   endfunction

   function automatic logic [7:0] non_hex_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      while (digit_value(b) >= 0) b = 8'($urandom_range(0, 255));
      return b;
   endfunction

   function automatic string describe(input result_type r);
      return $sformatf("byte %02h kind %0d length %0d last %0b",
                       r.out_byte, r.result_kind, r.decoded_length, r.last_of_run);
   endfunction

   task automatic flag_error(input string what);
      error_count++;
      if (error_count <= 10) $display("ERROR at %0t: %s", $time, what);
   endtask

   task automatic add_result(input logic [7:0] value, input kind_type kind);
      result_type r;
      if (kind == KIND_DATA && dec_length != '1) dec_length = dec_length + 1'b1;
      r.out_byte       = value;
      r.result_kind    = kind;
      r.decoded_length = (dec_length > 'hFFFF) ? 16'hFFFF : 16'(dec_length);
      r.last_of_run    = 1'b0;
      byte_results.push_back(r);
   endtask

   // work out the results that one accepted request causes
   task automatic decode_byte(input logic [7:0] b);
      int         digit;
      result_type last;
      byte_results.delete();
      case (dec_mode)
         MODE_PLAIN: begin
            if (b == dec_quote) begin
               add_result(8'h00, KIND_END);
               dec_mode = MODE_IDLE;
            end else if (b == CHAR_BSLASH) begin
               dec_mode = MODE_ESC;
            end else begin
               add_result(b, KIND_DATA);
            end
         end
         MODE_ESC: begin
            if (b == CHAR_X || b == CHAR_U) begin
               if (b == CHAR_X) dec_mode = MODE_HEX;
               else dec_mode = MODE_UNI;
               dec_digits = '0;
               dec_code   = '0;
            end else begin
               case (b)
                  CHAR_T:  add_result(CTRL_TAB, KIND_DATA);
                  CHAR_R:  add_result(CTRL_CR, KIND_DATA);
                  CHAR_N:  add_result(CTRL_LF, KIND_DATA);
                  default: add_result(b, KIND_DATA);
               endcase
               dec_mode = MODE_PLAIN;
            end
         end
         MODE_HEX, MODE_UNI: begin
            digit = digit_value(b);
            if (digit < 0) begin
               add_result(8'h00, KIND_ERR);
               dec_mode   = MODE_IDLE;
               dec_digits = '0;
               dec_code   = '0;
            end else begin
               dec_code = {dec_code[11:0], 4'(digit)};
               if (dec_mode == MODE_HEX && dec_digits >= 2'd1) begin
                  add_result(dec_code[7:0], KIND_DATA);
                  dec_mode   = MODE_PLAIN;
                  dec_digits = '0;
               end else if (dec_mode == MODE_UNI && dec_digits >= 2'd3) begin
                  if (dec_code <= UTF8_MAX1) begin
                     add_result(dec_code[7:0], KIND_DATA);
                  end else if (dec_code <= UTF8_MAX2) begin
                     add_result(UTF8_LEAD2 | {3'b000, dec_code[10:6]}, KIND_DATA);
                     add_result(UTF8_CONT | {2'b00, dec_code[5:0]}, KIND_DATA);
                  end else begin
                     add_result(UTF8_LEAD3 | {4'b0000, dec_code[15:12]}, KIND_DATA);
                     add_result(UTF8_CONT | {2'b00, dec_code[11:6]}, KIND_DATA);
                     add_result(UTF8_CONT | {2'b00, dec_code[5:0]}, KIND_DATA);
                  end
                  dec_mode   = MODE_PLAIN;
                  dec_digits = '0;
               end else begin
                  dec_digits = dec_digits + 1'b1;
               end
            end
         end
         default: begin
            // opening byte: skip it and start a fresh string
            dec_mode   = MODE_PLAIN;
            dec_digits = '0;
            dec_code   = '0;
            dec_length = '0;
         end
      endcase
      if (byte_results.size() > 0) begin
         last = byte_results.pop_back();
         last.last_of_run = 1'b1;
         byte_results.push_back(last);
      end
      foreach (byte_results[i]) expected_results.push_back(byte_results[i]);
   endtask

   task automatic send_byte(input logic [7:0] b);
      req_bus.valid   <= 1'b1;
      req_bus.in_byte <= b;
      req_offered = 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      decode_byte(b);
      bytes_sent++;
      if (req_idling && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         req_offered = 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) send_byte(text[i]);
   endtask

   // drop the request and hold until every result is back and the block is quiet
   task automatic wait_drained();
      if (req_offered) begin
         req_bus.valid <= 1'b0;
         req_offered = 1'b0;
      end
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input int index, input logic [CSR_DATA_W-1:0] value);
      wait_drained();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(index * 4);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (index == QUOTE_REG) dec_quote = value[7:0];
      // read the quote register back
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(QUOTE_REG * 4);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[7:0] !== dec_quote)
         flag_error($sformatf("quote register read %02h, expected %02h",
                              csr_prdata[7:0], dec_quote));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic test_plain_and_escapes();
      send_text("\"A\\t\\r\\n\\\"\\\\\\q");
      send_byte(8'h00);
      send_byte(8'hFF);
      send_text("\"");
   endtask

   task automatic test_hex_and_unicode();
      send_text("\"\\xfF\\x00\\u0041\\u0080\\u07Ff\\u0800\\uFFFF\"");
   endtask

   task automatic test_bad_hex_digits();
      send_text("\"a\\xg");
      send_text("\"\\u1G");
      // a quote among the hex digits is not a digit
      send_text("\"\\x4\"");
      send_text("\"b\"");
   endtask

   task automatic test_quote_settings();
      csr_write(QUOTE_REG, CSR_DATA_W'(CHAR_BSLASH));
      send_text("xa\\");
      // quote is a hex digit: taken as a digit inside \x, closes the string after
      csr_write(QUOTE_REG, CSR_DATA_W'(CHAR_UA));
      send_text("\"\\xA1A");
      csr_write(QUOTE_REG, 32'h0000_0000);
      send_text("\"z\\");
      send_byte(8'h00);
      send_byte(8'h00);
      csr_write(QUOTE_REG, 32'h0000_00FF);
      send_text("\"\\");
      send_byte(8'hFF);
      send_byte(8'hFF);
      csr_write(UNUSED_REG, 32'hFFFF_FF41);
      send_text("\"q");
      send_byte(8'hFF);
      csr_write(QUOTE_REG, CSR_DATA_W'(QUOTE_RESET));
   endtask

   task automatic test_backpressure();
      wait_drained();
      req_idling = 1'b0;
      long_hold_pending = 1'b1;
      send_text("\"");
      repeat (12) send_byte(plain_byte());
      send_text("\\uABCD\\u07Ff\\x5a");
      send_byte(dec_quote);
      wait_drained();
   endtask

   task automatic test_random_strings(input int count, input bit with_idling);
      int          target;
      int          pieces;
      bit          broken;
      logic [7:0]  b;
      logic [15:0] cp;
      target     = bytes_sent + count;
      rsp_idling = with_idling;
      while (bytes_sent < target) begin
         req_idling = with_idling && $urandom_range(0, 2) != 0;
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
         send_byte(8'($urandom_range(0, 255)));
         broken = 1'b0;
         pieces = $urandom_range(0, 8);
         for (int p = 0; p < pieces && !broken; p++) begin
            case ($urandom_range(0, 11))
               0, 1, 2, 3, 4: send_byte(plain_byte());
               5, 6: begin
                  send_byte(CHAR_BSLASH);
                  case ($urandom_range(0, 5))
                     0: b = CHAR_T;
                     1: b = CHAR_R;
                     2: b = CHAR_N;
                     3: b = dec_quote;
                     4: b = CHAR_BSLASH;
                     default: begin
                        b = 8'($urandom_range(0, 255));
                        while (b == CHAR_X || b == CHAR_U) b = 8'($urandom_range(0, 255));
                     end
                  endcase
                  send_byte(b);
               end
               7, 8: begin
                  b = 8'($urandom_range(0, 255));
                  send_byte(CHAR_BSLASH);
                  send_byte(CHAR_X);
                  send_byte(hex_char(b[7:4]));
                  send_byte(hex_char(b[3:0]));
               end
               9, 10: begin
                  case ($urandom_range(0, 2))
                     0: cp = 16'($urandom_range(0, 'h7F));
                     1: cp = 16'($urandom_range('h80, 'h7FF));
                     default: cp = 16'($urandom_range('h800, 'hFFFF));
                  endcase
                  send_byte(CHAR_BSLASH);
                  send_byte(CHAR_U);
                  for (int i = 3; i >= 0; i--) send_byte(hex_char(cp[4*i +: 4]));
               end
               default: begin
                  // bad digit part-way through an escape
                  send_byte(CHAR_BSLASH);
                  if ($urandom_range(0, 1)) begin
                     send_byte(CHAR_X);
                     repeat ($urandom_range(0, 1)) send_byte(hex_char(4'($urandom)));
                  end else begin
                     send_byte(CHAR_U);
                     repeat ($urandom_range(0, 3)) send_byte(hex_char(4'($urandom)));
                  end
                  send_byte(non_hex_byte());
                  broken = 1'b1;
               end
            endcase
         end
         if (!broken) send_byte(dec_quote);
      end
   endtask

   always @(posedge clock) begin
      result_type seen;
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen.out_byte       = rsp_bus.out_byte;
         seen.result_kind    = kind_type'(rsp_bus.result_kind);
         seen.decoded_length = rsp_bus.decoded_length;
         seen.last_of_run    = rsp_bus.last_of_run;
         if (expected_results.size() == 0) begin
            flag_error({"result with nothing expected: ", describe(seen)});
         end else begin
            want = expected_results.pop_front();
            if (seen.out_byte !== want.out_byte || seen.result_kind !== want.result_kind ||
                seen.decoded_length !== want.decoded_length ||
                seen.last_of_run !== want.last_of_run)
               flag_error({"expected ", describe(want), ", got ", describe(seen)});
         end
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_pending) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold_pending = 1'b0;
         end else if (rsp_idling && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(0, 11)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.in_byte = 8'h00;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      dec_mode        = MODE_IDLE;
      dec_digits      = '0;
      dec_code        = '0;
      dec_length      = '0;
      dec_quote       = QUOTE_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      req_idling = 1'b1;
      rsp_idling = 1'b1;
      test_plain_and_escapes();
      test_hex_and_unicode();
      test_bad_hex_digits();
      test_quote_settings();
      test_backpressure();

      csr_write(QUOTE_REG, 32'($urandom_range(0, 255)));
      test_random_strings(8, 1'b1);
      csr_write(QUOTE_REG, CSR_DATA_W'(QUOTE_RESET));
      test_random_strings(8, 1'b1);
      csr_write(QUOTE_REG, 32'($urandom_range(0, 255)));
      test_random_strings(6, 1'b1);
      csr_write(QUOTE_REG, CSR_DATA_W'(QUOTE_RESET));
      test_random_strings(6, 1'b0);

      wait_drained();
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### escaped_string_decoder.f
rtl/core/esd_pkg.sv
rtl/core/esd_req_if.sv
rtl/core/esd_rsp_if.sv
rtl/core/esd_csr.sv
rtl/core/esd_decode.sv
rtl/core/esd_out.sv
rtl/core/escaped_string_decoder.sv
tb/testbench.sv
